// File: hdl/weight_update_momentum_curvature_macros.svh
// Assertion macros shared by the weight update checker.
`ifndef WEIGHT_UPDATE_MOMENTUM_CURVATURE_MACROS_SVH
`define WEIGHT_UPDATE_MOMENTUM_CURVATURE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define WUMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, off while reset is held.
`define WUMC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication that stays live through reset.
`define WUMC_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// File: hdl/wumc_pkg.sv
// Shared types, constants and helpers of the weight update block.
`default_nettype none

package wumc_pkg;

  localparam int MOM_W = 17;
  localparam int RATE_W = 31;
  localparam int CFG_DW = 31;

  localparam logic [MOM_W-1:0] Q_ONE = 17'h10000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    CFG_GRAD_MOM_EARLY = 3'd0,
    CFG_CURV_MOM_EARLY = 3'd1,
    CFG_GRAD_MOM_LATE  = 3'd2,
    CFG_CURV_MOM_LATE  = 3'd3,
    CFG_RATE_WEIGHT    = 3'd4,
    CFG_RATE_BIAS      = 3'd5,
    CFG_DAMPING        = 3'd6
  } cfg_idx_t;

  typedef enum logic {
    MODE_LOAD   = 1'b0,
    MODE_UPDATE = 1'b1
  } mode_t;

  typedef struct packed {
    logic               mode;
    logic [9:0]         entry_index;
    logic               is_bias;
    logic [15:0]        iteration;
    logic signed [31:0] grad_or_weight;
    logic signed [31:0] second_deriv;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         out_index;
    logic signed [31:0] new_weight;
    logic               saturated;
  } out_item_t;

  // Momentum above one acts as one.
  function automatic logic [MOM_W-1:0] mom_clamp(input logic [MOM_W-1:0] m);
    return m[MOM_W-1] ? Q_ONE : m;
  endfunction

endpackage

`default_nettype wire

// File: hdl/wumc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wumc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Read-first: a read at the written address returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// File: hdl/wumc_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a tag line.
`default_nettype none

module wumc_div #(
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             vld_i,
  input  logic [TAG_W-1:0] tag_i,
  input  logic [32:0]      den_i,
  input  logic [32:0]      rem_i,
  input  logic [31:0]      num_i,
  output logic             vld_o,
  output logic [TAG_W-1:0] tag_o,
  output logic [31:0]      quo_o
);

  localparam int STEPS = 32;

  logic [STEPS-1:0] vld_r;
  logic [TAG_W-1:0] tag_r [STEPS];
  logic [32:0]      den_r [STEPS];
  logic [32:0]      rem_r [STEPS];
  logic [31:0]      num_r [STEPS];
  logic [31:0]      quo_r [STEPS];

  logic [TAG_W-1:0] tag_in  [STEPS];
  logic [32:0]      den_in  [STEPS];
  logic [32:0]      rem_in  [STEPS];
  logic [31:0]      num_in  [STEPS];
  logic [31:0]      quo_in  [STEPS];
  logic [32:0]      rem_nxt [STEPS];
  logic [31:0]      num_nxt [STEPS];
  logic [31:0]      quo_nxt [STEPS];

  always_comb begin
    logic [33:0] sh;
    logic [34:0] diff;
    tag_in[0] = tag_i;
    den_in[0] = den_i;
    rem_in[0] = rem_i;
    num_in[0] = num_i;
    quo_in[0] = '0;
    for (int i = 1; i < STEPS; i++) begin
      tag_in[i] = tag_r[i-1];
      den_in[i] = den_r[i-1];
      rem_in[i] = rem_r[i-1];
      num_in[i] = num_r[i-1];
      quo_in[i] = quo_r[i-1];
    end
    // Shift in the next numerator bit, subtract the divisor when it fits.
    for (int i = 0; i < STEPS; i++) begin
      sh = {rem_in[i], num_in[i][31]};
      diff = {1'b0, sh} - {2'b00, den_in[i]};
      rem_nxt[i] = diff[34] ? sh[32:0] : diff[32:0];
      num_nxt[i] = {num_in[i][30:0], 1'b0};
      quo_nxt[i] = {quo_in[i][30:0], ~diff[34]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[STEPS-2:0], vld_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tag_r <= tag_in;
      den_r <= den_in;
      rem_r <= rem_nxt;
      num_r <= num_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign vld_o = vld_r[STEPS-1];
  assign tag_o = tag_r[STEPS-1];
  assign quo_o = quo_r[STEPS-1];

endmodule

`default_nettype wire

// File: hdl/weight_update_momentum_curvature.sv
// Top level: per-entry weight, velocity and curvature update in Q16.16.
// Pipeline: 10 stages plus the 32-stage step-size divider, which sets the depth.
// Throughput: one transaction per cycle unless the output stalls or the clearing pass runs.
// Reset (synchronous, rst_n low) clears control and loads the register defaults, then a
// clearing pass over every entry zeroes the velocity and curvature memories with in_ready low.
// Configuration writes are taken at any time, cfg_ready is always high.
`default_nettype none

module weight_update_momentum_curvature #(
  parameter int ENTRIES = 1024,
  parameter int SWITCH_ITERATION = 30
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  wumc_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output wumc_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [30:0]         cfg_data
);

  import wumc_pkg::*;

  localparam int AW = $clog2(ENTRIES);
  localparam int unsigned RECIP = (1 << 20) / ENTRIES;

  // Item state that rides along the whole pipe.
  typedef struct packed {
    logic               mode;
    logic               is_bias;
    logic               late;
    logic [9:0]         out_index;
    logic [AW-1:0]      eidx;
    logic signed [31:0] gw;
    logic               sat;
  } pipe_t;

  typedef struct packed {
    pipe_t item;
    logic  neg;
    logic  zero;
    logic  big;
  } div_tag_t;

  // ---------------------------------------------------------------------------
  // Global advance: the whole pipe moves whenever the output register frees up.
  // ---------------------------------------------------------------------------
  logic adv;
  logic out_valid_r;
  out_item_t out_data_r;
  logic clr_active_r;
  logic [AW-1:0] clr_cnt_r;

  assign adv = !out_valid_r || out_ready;
  assign in_ready = adv && !clr_active_r;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [MOM_W-1:0]  grad_mom_early_r, curv_mom_early_r, grad_mom_late_r, curv_mom_late_r;
  logic [RATE_W-1:0] rate_weight_r, rate_bias_r, damping_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grad_mom_early_r <= 17'd32768;
      curv_mom_early_r <= 17'd32768;
      grad_mom_late_r  <= 17'd62259;
      curv_mom_late_r  <= 17'd62259;
      rate_weight_r    <= 31'd6554;
      rate_bias_r      <= 31'd6554;
      damping_r        <= 31'd655;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GRAD_MOM_EARLY: grad_mom_early_r <= cfg_data[MOM_W-1:0];
        CFG_CURV_MOM_EARLY: curv_mom_early_r <= cfg_data[MOM_W-1:0];
        CFG_GRAD_MOM_LATE:  grad_mom_late_r  <= cfg_data[MOM_W-1:0];
        CFG_CURV_MOM_LATE:  curv_mom_late_r  <= cfg_data[MOM_W-1:0];
        CFG_RATE_WEIGHT:    rate_weight_r    <= cfg_data;
        CFG_RATE_BIAS:      rate_bias_r      <= cfg_data;
        CFG_DAMPING:        damping_r        <= cfg_data;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: raw input. Reduce the index modulo ENTRIES with a reciprocal
  // multiply and one correction; start the curvature blend term.
  // ---------------------------------------------------------------------------
  logic     s1_vld_r;
  in_item_t s1_r;
  logic [29:0] mod_prod;
  logic [26:0] mod_qn, mod_rem;
  logic [AW-1:0] s1_eidx;
  logic s1_late;
  logic [MOM_W-1:0] s1_mc, s1_onem;
  logic signed [49:0] s1_term;
  pipe_t s1_item;

  always_comb begin
    mod_prod = {20'd0, s1_r.entry_index} * 30'(RECIP);
    mod_qn = {17'd0, mod_prod[29:20]} * 27'(ENTRIES);
    mod_rem = {17'd0, s1_r.entry_index} - mod_qn;
    s1_eidx = (mod_rem >= 27'(ENTRIES)) ? AW'(mod_rem - 27'(ENTRIES)) : AW'(mod_rem);
  end

  assign s1_late = s1_r.iteration >= 16'(SWITCH_ITERATION);
  assign s1_mc = mom_clamp(s1_late ? curv_mom_late_r : curv_mom_early_r);
  assign s1_onem = Q_ONE - s1_mc;
  assign s1_term = $signed({1'b0, s1_onem}) * s1_r.second_deriv;

  always_comb begin
    s1_item.mode = s1_r.mode;
    s1_item.is_bias = s1_r.is_bias;
    s1_item.late = s1_late;
    s1_item.out_index = s1_r.entry_index;
    s1_item.eidx = s1_eidx;
    s1_item.gw = s1_r.grad_or_weight;
    s1_item.sat = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stage 2: issue the curvature read. Stage 3: blend the old curvature with
  // the second derivative and write it back; forward the last write so that
  // the next item on the same entry sees it.
  // ---------------------------------------------------------------------------
  logic  s2_vld_r, s3_vld_r;
  pipe_t s2_r, s3_r;
  logic signed [49:0] s2_term_r, s3_term_r;
  logic [31:0] curv_rd;
  logic cfw_vld_r;
  logic [AW-1:0] cfw_idx_r;
  logic signed [31:0] cfw_data_r;
  logic signed [31:0] curv_old, curv_new;
  logic [MOM_W-1:0] s3_mc;
  logic signed [49:0] curv_sum;
  logic curv_we;
  logic [AW-1:0] curv_waddr;
  logic [31:0] curv_wdata;

  assign s3_mc = mom_clamp(s3_r.late ? curv_mom_late_r : curv_mom_early_r);
  assign curv_old = (cfw_vld_r && cfw_idx_r == s3_r.eidx) ? cfw_data_r : $signed(curv_rd);
  assign curv_sum = $signed({1'b0, s3_mc}) * curv_old + s3_term_r;
  // Load clears the entry; an update floors the blend (a convex mix stays in range).
  assign curv_new = (s3_r.mode == MODE_UPDATE) ? curv_sum[47:16] : 32'sd0;

  // The clearing pass owns the write port until it finishes.
  assign curv_we = clr_active_r || (adv && s3_vld_r);
  assign curv_waddr = clr_active_r ? clr_cnt_r : s3_r.eidx;
  assign curv_wdata = clr_active_r ? 32'd0 : curv_new;

  wumc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_curv_ram (
    .clk   (clk),
    .we    (curv_we),
    .waddr (curv_waddr),
    .wdata (curv_wdata),
    .re    (adv),
    .raddr (s2_r.eidx),
    .rdata (curv_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 4: form the divisor curvature + damping and the numerator rate << 16,
  // flag a zero divisor and a quotient that needs more than 32 bits.
  // ---------------------------------------------------------------------------
  logic  s4_vld_r;
  pipe_t s4_r;
  logic signed [31:0] s4_curv_r;
  logic [RATE_W-1:0] rate_sel;
  logic [33:0] dsum, dneg;
  logic [32:0] s4_absd, s4_rem0;
  div_tag_t s4_tag;

  assign rate_sel = s4_r.is_bias ? rate_bias_r : rate_weight_r;
  assign dsum = {{2{s4_curv_r[31]}}, s4_curv_r} + {3'b000, damping_r};
  assign dneg = 34'd0 - dsum;
  assign s4_absd = dsum[33] ? dneg[32:0] : dsum[32:0];
  assign s4_rem0 = {18'd0, rate_sel[30:16]};

  always_comb begin
    s4_tag.item = s4_r;
    s4_tag.neg = dsum[33];
    s4_tag.zero = (dsum == 34'd0);
    s4_tag.big = (s4_rem0 >= s4_absd);
  end

  // Stage 5: divider inputs.
  logic s5_vld_r;
  div_tag_t s5_tag_r;
  logic [32:0] s5_den_r, s5_rem_r;
  logic [31:0] s5_num_r;

  logic dv_vld;
  div_tag_t dv_tag;
  logic [31:0] dv_quo;

  wumc_div #(.TAG_W($bits(div_tag_t))) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (adv),
    .vld_i (s5_vld_r),
    .tag_i (s5_tag_r),
    .den_i (s5_den_r),
    .rem_i (s5_rem_r),
    .num_i (s5_num_r),
    .vld_o (dv_vld),
    .tag_o (dv_tag),
    .quo_o (dv_quo)
  );

  // ---------------------------------------------------------------------------
  // Divider exit: apply the divisor sign and clamp the step to 32 bits.
  // A zero divisor clamps to the positive limit.
  // ---------------------------------------------------------------------------
  logic signed [31:0] step_val;
  logic step_flag;
  pipe_t dv_item;

  always_comb begin
    step_val = dv_quo;
    step_flag = 1'b0;
    if (!dv_tag.neg) begin
      if (dv_tag.zero || dv_tag.big || dv_quo[31]) begin
        step_val = Q_MAX;
        step_flag = 1'b1;
      end
    end else begin
      if (dv_tag.big || (dv_quo[31] && (dv_quo[30:0] != 31'd0))) begin
        step_val = Q_MIN;
        step_flag = 1'b1;
      end else begin
        step_val = 32'sd0 - $signed(dv_quo);
      end
    end
    dv_item = dv_tag.item;
    dv_item.sat = dv_tag.item.sat | step_flag;
  end

  // Stage 6: gradient * step. Stage 7: floor to Q16.16 and clamp.
  logic  s6_vld_r, s7_vld_r, s8_vld_r;
  pipe_t s6_r, s7_r, s8_r;
  logic signed [31:0] s6_step_r;
  logic signed [63:0] s7_prod_r, s6_prod;
  logic prod_fits;
  logic signed [31:0] prod_sat;
  pipe_t s7_item;
  logic signed [31:0] s8_p_r;

  assign s6_prod = s6_r.gw * s6_step_r;
  assign prod_fits = (&s7_prod_r[63:47]) || !(|s7_prod_r[63:47]);
  assign prod_sat = prod_fits ? s7_prod_r[47:16] : (s7_prod_r[63] ? Q_MIN : Q_MAX);

  always_comb begin
    s7_item = s7_r;
    s7_item.sat = s7_r.sat | !prod_fits;
  end

  // ---------------------------------------------------------------------------
  // Stage 8 issues the velocity read and forms (one - m) * prod.
  // Stage 9: blend the velocity and write it back, with one-deep forwarding.
  // ---------------------------------------------------------------------------
  logic [MOM_W-1:0] s8_mg, s8_onem, s9_mg;
  logic signed [49:0] s8_term, s9_term_r, vel_sum;
  logic  s9_vld_r;
  pipe_t s9_r;
  logic [31:0] vel_rd;
  logic vfw_vld_r;
  logic [AW-1:0] vfw_idx_r;
  logic signed [31:0] vfw_data_r;
  logic signed [31:0] vel_old, vel_new;
  logic vel_we;
  logic [AW-1:0] vel_waddr;
  logic [31:0] vel_wdata;

  assign s8_mg = mom_clamp(s8_r.late ? grad_mom_late_r : grad_mom_early_r);
  assign s8_onem = Q_ONE - s8_mg;
  assign s8_term = $signed({1'b0, s8_onem}) * s8_p_r;

  assign s9_mg = mom_clamp(s9_r.late ? grad_mom_late_r : grad_mom_early_r);
  assign vel_old = (vfw_vld_r && vfw_idx_r == s9_r.eidx) ? vfw_data_r : $signed(vel_rd);
  assign vel_sum = $signed({1'b0, s9_mg}) * vel_old + s9_term_r;
  assign vel_new = (s9_r.mode == MODE_UPDATE) ? vel_sum[47:16] : 32'sd0;

  assign vel_we = clr_active_r || (adv && s9_vld_r);
  assign vel_waddr = clr_active_r ? clr_cnt_r : s9_r.eidx;
  assign vel_wdata = clr_active_r ? 32'd0 : vel_new;

  wumc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_vel_ram (
    .clk   (clk),
    .we    (vel_we),
    .waddr (vel_waddr),
    .wdata (vel_wdata),
    .re    (adv),
    .raddr (s8_r.eidx),
    .rdata (vel_rd)
  );

  // ---------------------------------------------------------------------------
  // Stage 10: weight minus velocity with clamping; a load writes the weight.
  // ---------------------------------------------------------------------------
  logic  s10_vld_r;
  pipe_t s10_r;
  logic signed [31:0] s10_vel_r;
  logic [31:0] wt_rd;
  logic wfw_vld_r;
  logic [AW-1:0] wfw_idx_r;
  logic signed [31:0] wfw_data_r;
  logic signed [31:0] wt_old, wt_new;
  logic [32:0] wt_diff;
  logic wt_ovf;
  out_item_t out_nxt;

  assign wt_old = (wfw_vld_r && wfw_idx_r == s10_r.eidx) ? wfw_data_r : $signed(wt_rd);
  assign wt_diff = {wt_old[31], wt_old} - {s10_vel_r[31], s10_vel_r};
  assign wt_ovf = wt_diff[32] != wt_diff[31];

  always_comb begin
    if (s10_r.mode == MODE_UPDATE) begin
      wt_new = wt_ovf ? (wt_diff[32] ? Q_MIN : Q_MAX) : $signed(wt_diff[31:0]);
    end else begin
      wt_new = s10_r.gw;
    end
    out_nxt.out_index = s10_r.out_index;
    out_nxt.new_weight = wt_new;
    out_nxt.saturated = (s10_r.mode == MODE_UPDATE) && (s10_r.sat || wt_ovf);
  end

  wumc_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_wt_ram (
    .clk   (clk),
    .we    (adv && s10_vld_r),
    .waddr (s10_r.eidx),
    .wdata (wt_new),
    .re    (adv),
    .raddr (s9_r.eidx),
    .rdata (wt_rd)
  );

  // ---------------------------------------------------------------------------
  // Control: valid bits, forwarding valids and the clearing pass.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r     <= 1'b0;
      s2_vld_r     <= 1'b0;
      s3_vld_r     <= 1'b0;
      s4_vld_r     <= 1'b0;
      s5_vld_r     <= 1'b0;
      s6_vld_r     <= 1'b0;
      s7_vld_r     <= 1'b0;
      s8_vld_r     <= 1'b0;
      s9_vld_r     <= 1'b0;
      s10_vld_r    <= 1'b0;
      out_valid_r  <= 1'b0;
      cfw_vld_r    <= 1'b0;
      vfw_vld_r    <= 1'b0;
      wfw_vld_r    <= 1'b0;
      clr_active_r <= 1'b1;
      clr_cnt_r    <= '0;
    end else begin
      if (adv) begin
        s1_vld_r    <= in_valid && in_ready;
        s2_vld_r    <= s1_vld_r;
        s3_vld_r    <= s2_vld_r;
        s4_vld_r    <= s3_vld_r;
        s5_vld_r    <= s4_vld_r;
        s6_vld_r    <= dv_vld;
        s7_vld_r    <= s6_vld_r;
        s8_vld_r    <= s7_vld_r;
        s9_vld_r    <= s8_vld_r;
        s10_vld_r   <= s9_vld_r;
        out_valid_r <= s10_vld_r;
        cfw_vld_r   <= s3_vld_r;
        vfw_vld_r   <= s9_vld_r;
        wfw_vld_r   <= s10_vld_r;
      end
      // Sweep one entry per cycle, then open the input.
      if (clr_active_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == AW'(ENTRIES - 1)) begin
          clr_active_r <= 1'b0;
        end
      end
    end
  end

  // Payload: hold everything while the output waits.
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r       <= in_data;
      s2_r       <= s1_item;
      s2_term_r  <= s1_term;
      s3_r       <= s2_r;
      s3_term_r  <= s2_term_r;
      s4_r       <= s3_r;
      s4_curv_r  <= curv_new;
      cfw_idx_r  <= s3_r.eidx;
      cfw_data_r <= curv_new;
      s5_tag_r   <= s4_tag;
      s5_den_r   <= s4_absd;
      s5_rem_r   <= s4_rem0;
      s5_num_r   <= {rate_sel[15:0], 16'h0000};
      s6_r       <= dv_item;
      s6_step_r  <= step_val;
      s7_r       <= s6_r;
      s7_prod_r  <= s6_prod;
      s8_r       <= s7_item;
      s8_p_r     <= prod_sat;
      s9_r       <= s8_r;
      s9_term_r  <= s8_term;
      s10_r      <= s9_r;
      s10_vel_r  <= vel_new;
      vfw_idx_r  <= s9_r.eidx;
      vfw_data_r <= vel_new;
      wfw_idx_r  <= s10_r.eidx;
      wfw_data_r <= wt_new;
      out_data_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hdl/wumc_checker.sv
// Port-level checker for the weight update block, bound to the top level.
`default_nettype none

`include "weight_update_momentum_curvature_macros.svh"

module wumc_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input wumc_pkg::out_item_t out_data
);

  // A stalled result holds.
  `WUMC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_data))
  // Input is only open when the pipe can move.
  `WUMC_ASSERT_IMP(a_in_needs_adv, clk, rst_n, in_ready, !out_valid || out_ready)
  // Reset empties the output and starts the clearing pass.
  `WUMC_ASSERT_RST(a_rst_out, clk, !rst_n, !out_valid)
  `WUMC_ASSERT_RST(a_rst_clear, clk, !rst_n, !in_ready)

endmodule

bind weight_update_momentum_curvature wumc_checker u_wumc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

// File: bench/weight_update_momentum_curvature_tb.sv
// Self-checking bench for the Q16.16 momentum and curvature weight update block.
`timescale 1ns / 100ps
`default_nettype none

module weight_update_momentum_curvature_tb;
  import wumc_pkg::*;

  localparam int NUM_ENTRIES = 1024;
  localparam int SWITCH_ITER = 30;
  localparam int PIPE_LATENCY = 43;
  localparam longint MAX_CYCLES = 2000000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;

  weight_update_momentum_curvature #(
    .ENTRIES(NUM_ENTRIES),
    .SWITCH_ITERATION(SWITCH_ITER)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state: register shadow and per-entry stores.
  logic [30:0] reg_shadow [7];
  logic signed [31:0] pred_weight [NUM_ENTRIES];
  logic signed [31:0] pred_vel [NUM_ENTRIES];
  logic signed [31:0] pred_curv [NUM_ENTRIES];
  bit loaded [NUM_ENTRIES];

  in_item_t pending_items[$];
  out_item_t expected_updates[$];

  int send_idle_pct;
  int stall_pct;
  int mismatches;
  int results_seen;
  int loads_sent;
  int updates_sent;
  int sat_seen;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Cycle limit: end the run with a failure on a hang.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_updates.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint floor_q16(longint x);
    longint q;
    q = x / 65536;
    if ((x % 65536) < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint clamp_i32(longint x, ref bit clipped);
    if (x > 64'sd2147483647) begin
      clipped = 1'b1;
      return 64'sd2147483647;
    end
    if (x < -64'sd2147483648) begin
      clipped = 1'b1;
      return -64'sd2147483648;
    end
    return x;
  endfunction

  function automatic longint eff_momentum(logic [30:0] r);
    return (r[16:0] > 17'h10000) ? 65536 : longint'(r[16:0]);
  endfunction

  // Compute the result of one transaction and advance the predictor stores.
  function automatic out_item_t apply_update(in_item_t it);
    out_item_t r;
    int e;
    bit clipped;
    bit late;
    longint mg, mc, rate, curv, dv, step, prod, vel, w, gw, d2;
    e = int'(it.entry_index) % NUM_ENTRIES;
    clipped = 1'b0;
    gw = longint'(it.grad_or_weight);
    d2 = longint'(it.second_deriv);
    if (it.mode == MODE_LOAD) begin
      pred_weight[e] = it.grad_or_weight;
      pred_vel[e] = '0;
      pred_curv[e] = '0;
      w = gw;
    end else begin
      late = it.iteration >= SWITCH_ITER;
      mg = eff_momentum(late ? reg_shadow[CFG_GRAD_MOM_LATE] : reg_shadow[CFG_GRAD_MOM_EARLY]);
      mc = eff_momentum(late ? reg_shadow[CFG_CURV_MOM_LATE] : reg_shadow[CFG_CURV_MOM_EARLY]);
      rate = longint'(it.is_bias ? reg_shadow[CFG_RATE_BIAS] : reg_shadow[CFG_RATE_WEIGHT]);
      curv = clamp_i32(floor_q16(mc * longint'(pred_curv[e]) + (65536 - mc) * d2), clipped);
      dv = curv + longint'(reg_shadow[CFG_DAMPING]);
      if (dv == 0) begin
        step = 64'sd2147483647;
        clipped = 1'b1;
      end else begin
        step = clamp_i32((rate * 65536) / dv, clipped);
      end
      prod = clamp_i32(floor_q16(gw * step), clipped);
      vel = clamp_i32(floor_q16(mg * longint'(pred_vel[e]) + (65536 - mg) * prod), clipped);
      w = clamp_i32(longint'(pred_weight[e]) - vel, clipped);
      pred_curv[e] = curv[31:0];
      pred_vel[e] = vel[31:0];
      pred_weight[e] = w[31:0];
    end
    r.out_index = it.entry_index;
    r.new_weight = w[31:0];
    r.saturated = clipped;
    return r;
  endfunction

  // Driver: hold each transaction until accepted, idle at random between them.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      expected_updates.push_back(apply_update(in_data));
      if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= pending_items.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end else if (!in_valid && pending_items.size() != 0 &&
                 $urandom_range(99) >= send_idle_pct) begin
      in_valid <= 1'b1;
      in_data <= pending_items.pop_front();
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_updates.size() == 0) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_updates.pop_front();
          if (out_data.saturated) sat_seen <= sat_seen + 1;
          if (out_data !== want) begin
            mismatches = mismatches + 1;
            if (mismatches <= 10)
              $display("mismatch: idx exp %0d got %0d, weight exp %0d got %0d, sat exp %0b got %0b",
                       want.out_index, out_data.out_index, want.new_weight,
                       out_data.new_weight, want.saturated, out_data.saturated);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [30:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_shadow[idx] = (idx <= CFG_CURV_MOM_LATE) ? {14'd0, value[16:0]} : value;
  endtask

  // Wait for every expected result, then let the pipeline drain.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || expected_updates.size() != 0)
      @(posedge clk);
    repeat (PIPE_LATENCY + 5) @(posedge clk);
  endtask

  function automatic in_item_t make_item(bit mode, logic [9:0] idx, bit bias,
                                         logic [15:0] iter, logic [31:0] g, logic [31:0] d);
    in_item_t it;
    it.mode = mode;
    it.entry_index = idx;
    it.is_bias = bias;
    it.iteration = iter;
    it.grad_or_weight = g;
    it.second_deriv = d;
    return it;
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 400000)) - 200000);
      default: return 32'(int'($urandom_range(0, 20000)) - 10000);
    endcase
  endfunction

  // Queue one random transaction, keeping updates on loaded entries only.
  task automatic queue_random(int span);
    logic [9:0] idx;
    bit mode;
    idx = 10'($urandom_range(0, span - 1));
    mode = loaded[idx] && ($urandom_range(9) != 0);
    loaded[idx] = 1'b1;
    if (mode) updates_sent++;
    else loads_sent++;
    pending_items.push_back(make_item(mode, idx, $urandom_range(0, 1), 16'($urandom()),
                                      rand_q(), rand_q()));
  endtask

  // One random phase: a stretch of traffic at the given idle and stall odds, then a drain.
  task automatic run_phase(int n, int idle, int stall, int span);
    send_idle_pct = idle;
    stall_pct = stall;
    for (int i = 0; i < n; i++) queue_random(span);
    drain();
  endtask

  initial begin
    logic [30:0] mom_pick [4];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_GRAD_MOM_EARLY;
    cfg_data = '0;
    cycle_count = 0;
    mismatches = 0;
    results_seen = 0;
    sat_seen = 0;
    loads_sent = 0;
    updates_sent = 0;
    send_idle_pct = 0;
    stall_pct = 0;
    reg_shadow[CFG_GRAD_MOM_EARLY] = 32768;
    reg_shadow[CFG_CURV_MOM_EARLY] = 32768;
    reg_shadow[CFG_GRAD_MOM_LATE] = 62259;
    reg_shadow[CFG_CURV_MOM_LATE] = 62259;
    reg_shadow[CFG_RATE_WEIGHT] = 6554;
    reg_shadow[CFG_RATE_BIAS] = 6554;
    reg_shadow[CFG_DAMPING] = 655;
    for (int e = 0; e < NUM_ENTRIES; e++) begin
      pred_weight[e] = '0;
      pred_vel[e] = '0;
      pred_curv[e] = '0;
      loaded[e] = 1'b0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, both modes, the switch boundary, clamps.
    pending_items.push_back(make_item(MODE_LOAD, 10'd0, 1'b0, 16'd0, 32'h7FFF_FFFF, 32'd0));
    pending_items.push_back(make_item(MODE_LOAD, 10'd1023, 1'b1, 16'hFFFF, 32'h8000_0000,
                                      32'hFFFF_FFFF));
    pending_items.push_back(make_item(MODE_LOAD, 10'd5, 1'b0, 16'd0, 32'h0001_0000, 32'd0));
    pending_items.push_back(make_item(MODE_UPDATE, 10'd5, 1'b0, 16'd29, 32'h0000_8000,
                                      32'h0002_0000));
    pending_items.push_back(make_item(MODE_UPDATE, 10'd5, 1'b1, 16'd30, 32'hFFFF_8000,
                                      32'h0001_0000));
    pending_items.push_back(make_item(MODE_UPDATE, 10'd0, 1'b0, 16'hFFFF, 32'h8000_0000,
                                      32'h8000_0000));
    pending_items.push_back(make_item(MODE_UPDATE, 10'd1023, 1'b1, 16'd0, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF));
    pending_items.push_back(make_item(MODE_UPDATE, 10'd0, 1'b1, 16'd31, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF));
    loaded[0] = 1; loaded[1023] = 1; loaded[5] = 1;
    send_idle_pct = 0;
    stall_pct = 0;
    drain();

    // Zero divisor: damping zero on a cleared curvature with zero second derivative.
    write_reg(CFG_DAMPING, 31'd0);
    write_reg(CFG_CURV_MOM_EARLY, 31'h1FFFF);
    write_reg(CFG_GRAD_MOM_EARLY, 31'd0);
    write_reg(CFG_RATE_WEIGHT, 31'h7FFF_FFFF);
    write_reg(CFG_RATE_BIAS, 31'd0);
    write_reg(CFG_GRAD_MOM_LATE, 31'h10000);
    write_reg(CFG_CURV_MOM_LATE, 31'd0);
    pending_items.push_back(make_item(MODE_LOAD, 10'd7, 1'b0, 16'd0, 32'd100, 32'd0));
    pending_items.push_back(make_item(MODE_UPDATE, 10'd7, 1'b0, 16'd3, 32'h0001_0000, 32'd0));
    pending_items.push_back(make_item(MODE_UPDATE, 10'd7, 1'b1, 16'd3, 32'h7FFF_FFFF, 32'd5));
    pending_items.push_back(make_item(MODE_UPDATE, 10'd7, 1'b0, 16'd40, 32'h8000_0000,
                                      32'hFFFF_0000));
    pending_items.push_back(make_item(MODE_UPDATE, 10'd7, 1'b1, 16'd40, 32'h0000_1000,
                                      32'h0001_0000));
    loaded[7] = 1;
    drain();

    // Random phases over several register settings; small entry spans revisit entries.
    for (int p = 0; p < 12; p++) begin
      for (int k = 0; k < 4; k++) begin
        case ($urandom_range(3))
          0: mom_pick[k] = 31'($urandom_range(0, 65536));
          1: mom_pick[k] = 31'h10000;
          2: mom_pick[k] = 31'($urandom_range(65537, 131071));
          default: mom_pick[k] = 31'($urandom_range(0, 3)) * 31'd16384;
        endcase
      end
      write_reg(CFG_GRAD_MOM_EARLY, mom_pick[0]);
      write_reg(CFG_CURV_MOM_EARLY, mom_pick[1]);
      write_reg(CFG_GRAD_MOM_LATE, mom_pick[2]);
      write_reg(CFG_CURV_MOM_LATE, mom_pick[3]);
      write_reg(CFG_RATE_WEIGHT, (p % 3 == 0) ? 31'h7FFF_FFFF : 31'($urandom_range(0, 200000)));
      write_reg(CFG_RATE_BIAS, (p % 4 == 1) ? 31'd0 : 31'($urandom()));
      write_reg(CFG_DAMPING, (p % 3 == 2) ? 31'd0 : 31'($urandom_range(0, 70000)));
      case (p % 4)
        0: run_phase(145, 0, 0, (p < 6) ? 16 : 1024);
        1: run_phase(145, 85, 0, 32);
        2: run_phase(145, 0, 85, 64);
        default: run_phase(145, 19, 19, 8);
      endcase
    end

    $display("covered %0d loads and %0d updates, %0d results checked, %0d flagged saturated",
             loads_sent, updates_sent, results_seen, sat_seen);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: files.f
+incdir+hdl
hdl/wumc_pkg.sv
hdl/wumc_ram.sv
hdl/wumc_div.sv
hdl/weight_update_momentum_curvature.sv
hdl/wumc_checker.sv
bench/weight_update_momentum_curvature_tb.sv
